// ===== rtl/bmzd_pkg.sv =====
// ----------------------------------------------------------------------------
// Band motion zone detector package
// Shared constants, configuration record and queue item type.
// ----------------------------------------------------------------------------
`default_nettype none
package bmzd_pkg;

  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;
  localparam int PIX_COUNT    = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W       = $clog2(PIX_COUNT);

  localparam int XW        = 10;
  localparam int YW        = 9;
  localparam int CHW       = 8;
  localparam int CNT_W     = 19;
  localparam int ZONE_W    = 3;
  localparam int NUM_ZONES = 5;
  localparam int START_W   = 13;
  localparam int PROD_W    = 42;
  localparam int SUM_W     = 43;
  localparam int C_W       = SUM_W - 16;
  localparam int BAND_W    = C_W + 1;

  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [CHW-1:0]   CH_FULL   = 8'd255;
  localparam logic [ZONE_W-1:0] ZONE_LAST = 3'd4;
  localparam logic [ZONE_W-1:0] ZONE_FIRST_PICK = 3'd3;

  typedef enum logic [2:0] {
    REG_LINE_SLOPE     = 3'd0,
    REG_LINE_INTERCEPT = 3'd1,
    REG_X_LEFT         = 3'd2,
    REG_X_RIGHT        = 3'd3,
    REG_ZONE_WIDTH     = 3'd4,
    REG_BAND_HALF      = 3'd5,
    REG_DIFF_THRESH    = 3'd6,
    REG_ACTION_THRESH  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] line_slope;
    logic signed [31:0] line_intercept;
    logic [XW-1:0]      x_left;
    logic [XW-1:0]      x_right;
    logic [XW-1:0]      zone_width;
    logic [7:0]         band_half_width;
    logic [7:0]         pixel_diff_threshold;
    logic [CNT_W-1:0]   action_threshold;
  } cfg_t;

  typedef struct packed {
    logic [CHW-1:0]    blue;
    logic [CHW-1:0]    green;
    logic [CHW-1:0]    red;
    logic [ADDR_W-1:0] addr;
    logic              in_frame;
    logic              capture;
    logic              last;
    logic              watch;
    logic              edge_mark;
    logic [ZONE_W-1:0] zone;
  } item_t;

endpackage
`default_nettype wire

// ===== rtl/bmzd_front.sv =====
// ----------------------------------------------------------------------------
// Band motion zone detector front end
// Accepts pixels, works out band and zone geometry in three stages.
// ----------------------------------------------------------------------------
`default_nettype none
module bmzd_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire bmzd_pkg::cfg_t           cfg,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [47:0]              in_tdata,  // pix_x, pix_y, in_blue, in_green, in_red
  input  wire logic                     in_tuser,  // capture_frame
  input  wire logic                     in_tlast,  // frame_end
  input  wire logic [bmzd_pkg::QPTR_W:0] q_count,
  output logic                          push_valid,
  output bmzd_pkg::item_t               push_item
);

  localparam int OCC_W = bmzd_pkg::QPTR_W + 2;

  logic [OCC_W-1:0] occ;
  logic             accept;

  // stage 1
  logic                                 f1_v_r;
  logic [bmzd_pkg::XW-1:0]              f1_x_r;
  logic [bmzd_pkg::YW-1:0]              f1_y_r;
  logic [3*bmzd_pkg::CHW-1:0]           f1_pix_r;
  logic                                 f1_cap_r, f1_last_r, f1_inf_r;
  logic [bmzd_pkg::ADDR_W-1:0]          f1_addr_r;
  logic signed [bmzd_pkg::PROD_W-1:0]   f1_prod_r;
  // stage 2
  logic                                 f2_v_r;
  logic [bmzd_pkg::YW-1:0]              f2_y_r;
  logic [3*bmzd_pkg::CHW-1:0]           f2_pix_r;
  logic                                 f2_cap_r, f2_last_r, f2_inf_r;
  logic [bmzd_pkg::ADDR_W-1:0]          f2_addr_r;
  logic signed [bmzd_pkg::SUM_W-1:0]    f2_sum_r;
  logic                                 f2_cols_r, f2_vert_r;
  logic [bmzd_pkg::ZONE_W-1:0]          f2_zone_r;
  // stage 3
  logic                                 f3_v_r;
  logic [bmzd_pkg::YW-1:0]              f3_y_r;
  logic [3*bmzd_pkg::CHW-1:0]           f3_pix_r;
  logic                                 f3_cap_r, f3_last_r, f3_inf_r;
  logic [bmzd_pkg::ADDR_W-1:0]          f3_addr_r;
  logic signed [bmzd_pkg::C_W-1:0]      f3_c_r;
  logic                                 f3_cols_r, f3_vert_r;
  logic [bmzd_pkg::ZONE_W-1:0]          f3_zone_r;

  logic [bmzd_pkg::XW-1:0]    in_x;
  logic [bmzd_pkg::YW-1:0]    in_y;
  logic [bmzd_pkg::START_W-1:0] starts [bmzd_pkg::NUM_ZONES];
  logic                       vert;
  logic [bmzd_pkg::ZONE_W-1:0] zone;
  logic signed [bmzd_pkg::SUM_W-1:0] sum;
  logic signed [bmzd_pkg::C_W-1:0]   c_floor;
  logic signed [bmzd_pkg::BAND_W-1:0] lo, hi, yy;
  logic                       on_edge, in_band;

  assign occ = OCC_W'(q_count) + OCC_W'(f1_v_r) + OCC_W'(f2_v_r) + OCC_W'(f3_v_r);
  assign in_tready = occ < OCC_W'(bmzd_pkg::QDEPTH);
  assign accept = in_tvalid && in_tready;
  assign in_x = in_tdata[9:0];
  assign in_y = in_tdata[18:10];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
    end else begin
      f1_v_r <= accept;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
    end
  end

  // Zone starts and vertical edge marks.
  always_comb begin
    vert = (f1_x_r == cfg.x_left) || (f1_x_r == cfg.x_right);
    for (int k = 0; k < bmzd_pkg::NUM_ZONES; k++) begin
      starts[k] = bmzd_pkg::START_W'(cfg.x_left) +
                  bmzd_pkg::START_W'(cfg.zone_width) * bmzd_pkg::START_W'(k);
      if (bmzd_pkg::START_W'(f1_x_r) == starts[k]) vert = 1'b1;
    end
    priority if (bmzd_pkg::START_W'(f1_x_r) > starts[4]) zone = 3'd4;
    else if (bmzd_pkg::START_W'(f1_x_r) > starts[3]) zone = 3'd3;
    else if (bmzd_pkg::START_W'(f1_x_r) > starts[2]) zone = 3'd2;
    else if (bmzd_pkg::START_W'(f1_x_r) > starts[1]) zone = 3'd1;
    else zone = 3'd0;
  end

  assign sum = bmzd_pkg::SUM_W'(f1_prod_r) + bmzd_pkg::SUM_W'(cfg.line_intercept);
  // Centre row truncates toward zero, so negative values with a fraction go up one.
  assign c_floor = bmzd_pkg::C_W'(f2_sum_r >>> 16);

  always_ff @(posedge clk) begin
    f1_x_r    <= in_x;
    f1_y_r    <= in_y;
    f1_pix_r  <= in_tdata[42:19];
    f1_cap_r  <= in_tuser;
    f1_last_r <= in_tlast;
    f1_inf_r  <= (32'(in_x) < bmzd_pkg::FRAME_WIDTH) && (32'(in_y) < bmzd_pkg::FRAME_HEIGHT);
    f1_addr_r <= bmzd_pkg::ADDR_W'(bmzd_pkg::ADDR_W'(in_y) *
                 bmzd_pkg::ADDR_W'(bmzd_pkg::FRAME_WIDTH) + bmzd_pkg::ADDR_W'(in_x));
    f1_prod_r <= bmzd_pkg::PROD_W'(cfg.line_slope * $signed({1'b0, in_x}));

    f2_y_r    <= f1_y_r;
    f2_pix_r  <= f1_pix_r;
    f2_cap_r  <= f1_cap_r;
    f2_last_r <= f1_last_r;
    f2_inf_r  <= f1_inf_r;
    f2_addr_r <= f1_addr_r;
    f2_sum_r  <= sum;
    f2_cols_r <= (f1_x_r >= cfg.x_left) && (f1_x_r <= cfg.x_right);
    f2_vert_r <= vert;
    f2_zone_r <= zone;

    f3_y_r    <= f2_y_r;
    f3_pix_r  <= f2_pix_r;
    f3_cap_r  <= f2_cap_r;
    f3_last_r <= f2_last_r;
    f3_inf_r  <= f2_inf_r;
    f3_addr_r <= f2_addr_r;
    f3_c_r    <= c_floor + bmzd_pkg::C_W'(f2_sum_r[bmzd_pkg::SUM_W-1] && (f2_sum_r[15:0] != '0));
    f3_cols_r <= f2_cols_r;
    f3_vert_r <= f2_vert_r;
    f3_zone_r <= f2_zone_r;
  end

  assign lo = bmzd_pkg::BAND_W'(f3_c_r) - $signed(bmzd_pkg::BAND_W'(cfg.band_half_width));
  assign hi = bmzd_pkg::BAND_W'(f3_c_r) + $signed(bmzd_pkg::BAND_W'(cfg.band_half_width));
  assign yy = $signed(bmzd_pkg::BAND_W'(f3_y_r));
  assign on_edge = (yy == lo) || (yy == hi);
  assign in_band = (yy >= lo) && (yy <= hi);

  always_comb begin
    push_valid          = f3_v_r;
    push_item.blue      = f3_pix_r[7:0];
    push_item.green     = f3_pix_r[15:8];
    push_item.red       = f3_pix_r[23:16];
    push_item.addr      = f3_addr_r;
    push_item.in_frame  = f3_inf_r;
    push_item.capture   = f3_cap_r;
    push_item.last      = f3_last_r;
    push_item.watch     = in_band && f3_cols_r && f3_inf_r;
    push_item.edge_mark = (on_edge && f3_cols_r) || (in_band && f3_vert_r);
    push_item.zone      = f3_zone_r;
  end

endmodule
`default_nettype wire

// ===== rtl/bmzd_queue.sv =====
// ----------------------------------------------------------------------------
// Band motion zone detector item queue
// Short FIFO between the geometry front end and the compare back end.
// ----------------------------------------------------------------------------
`default_nettype none
module bmzd_queue (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push_valid,
  input  wire bmzd_pkg::item_t           push_item,
  input  wire logic                      pop,
  output logic                           q_valid,
  output bmzd_pkg::item_t                q_item,
  output logic [bmzd_pkg::QPTR_W:0]      q_count
);

  bmzd_pkg::item_t                  slot_r [bmzd_pkg::QDEPTH];
  logic [bmzd_pkg::QPTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [bmzd_pkg::QPTR_W:0]        count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_valid) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + (bmzd_pkg::QPTR_W+1)'(push_valid) - (bmzd_pkg::QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) slot_r[wr_ptr_r] <= push_item;
  end

  assign q_valid = count_r != '0;
  assign q_item  = slot_r[rd_ptr_r];
  assign q_count = count_r;

endmodule
`default_nettype wire

// ===== rtl/bmzd_back.sv =====
// ----------------------------------------------------------------------------
// Band motion zone detector back end
// Reference store, motion compare, zone counts, report and output register.
// ----------------------------------------------------------------------------
`default_nettype none
module bmzd_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire bmzd_pkg::cfg_t  cfg,
  input  wire logic            q_valid,
  input  wire bmzd_pkg::item_t q_item,
  output logic                 q_pop,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [31:0]          out_tdata,  // out_blue, out_green, out_red, action_valid, action_zone
  output logic                 out_tlast   // frame_last
);

  logic [3*bmzd_pkg::CHW-1:0] ref_mem [bmzd_pkg::PIX_COUNT];

  logic                        b_v_r;
  bmzd_pkg::item_t             b_r;
  logic [3*bmzd_pkg::CHW-1:0]  rd_data_r;
  logic                        fw_v_r;
  logic [bmzd_pkg::ADDR_W-1:0] fw_addr_r;
  logic [3*bmzd_pkg::CHW-1:0]  fw_data_r;
  logic [bmzd_pkg::CNT_W-1:0]  cnt_r   [bmzd_pkg::NUM_ZONES];
  logic [bmzd_pkg::CNT_W-1:0]  cnt_inc [bmzd_pkg::NUM_ZONES];
  logic                        out_valid_r, out_last_r;
  logic [31:0]                 out_data_r;

  logic                        advance, motion, hit, wr_en, report;
  logic [3*bmzd_pkg::CHW-1:0]  ref_pix, cam_pix;
  logic [bmzd_pkg::CHW-1:0]    d_b, d_g, d_r, o_b, o_g, o_r;
  logic [bmzd_pkg::ZONE_W-1:0] pick;

  assign advance = b_v_r && (!out_valid_r || out_tready);
  assign q_pop   = q_valid && (!b_v_r || advance);
  assign cam_pix = {b_r.red, b_r.green, b_r.blue};

  // The item ahead may have written this address on the edge that read it.
  assign ref_pix = (fw_v_r && fw_addr_r == b_r.addr) ? fw_data_r : rd_data_r;

  always_comb begin
    d_b = (b_r.blue  > ref_pix[7:0])   ? b_r.blue  - ref_pix[7:0]   : ref_pix[7:0]   - b_r.blue;
    d_g = (b_r.green > ref_pix[15:8])  ? b_r.green - ref_pix[15:8]  : ref_pix[15:8]  - b_r.green;
    d_r = (b_r.red   > ref_pix[23:16]) ? b_r.red   - ref_pix[23:16] : ref_pix[23:16] - b_r.red;
    motion = (d_b > cfg.pixel_diff_threshold) || (d_g > cfg.pixel_diff_threshold) ||
             (d_r > cfg.pixel_diff_threshold);
  end

  assign hit   = !b_r.capture && b_r.watch && motion;
  assign wr_en = advance && b_r.in_frame && (b_r.capture || hit);

  always_comb begin
    for (int k = 0; k < bmzd_pkg::NUM_ZONES; k++) begin
      cnt_inc[k] = cnt_r[k] + bmzd_pkg::CNT_W'(hit && b_r.zone == bmzd_pkg::ZONE_W'(k) &&
                                               cnt_r[k] != bmzd_pkg::COUNT_MAX);
    end
    pick = bmzd_pkg::ZONE_FIRST_PICK;
    if (cnt_inc[4] > cnt_inc[pick]) pick = 3'd4;
    if (cnt_inc[2] > cnt_inc[pick]) pick = 3'd2;
    if (cnt_inc[1] > cnt_inc[pick]) pick = 3'd1;
    if (cnt_inc[0] > cnt_inc[pick]) pick = 3'd0;
    report = !b_r.capture && b_r.last && (cnt_inc[pick] > cfg.action_threshold);
  end

  always_comb begin
    priority if (b_r.capture) begin
      {o_r, o_g, o_b} = cam_pix;
    end else if (hit) begin
      {o_r, o_g, o_b} = {bmzd_pkg::CH_FULL, 8'd0, 8'd0};
    end else if (b_r.edge_mark) begin
      {o_r, o_g, o_b} = {8'd0, bmzd_pkg::CH_FULL, 8'd0};
    end else begin
      {o_r, o_g, o_b} = cam_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) ref_mem[b_r.addr] <= cam_pix;
    if (q_pop) rd_data_r <= ref_mem[q_item.addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r       <= 1'b0;
      fw_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < bmzd_pkg::NUM_ZONES; k++) cnt_r[k] <= '0;
    end else begin
      if (q_pop) b_v_r <= 1'b1;
      else if (advance) b_v_r <= 1'b0;
      if (wr_en) fw_v_r <= 1'b1;
      if (advance) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (advance) begin
        for (int k = 0; k < bmzd_pkg::NUM_ZONES; k++) begin
          cnt_r[k] <= b_r.last ? '0 : cnt_inc[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) b_r <= q_item;
    if (wr_en) begin
      fw_addr_r <= b_r.addr;
      fw_data_r <= cam_pix;
    end
    if (advance) begin
      out_data_r <= {4'd0, report ? pick : 3'd0, report, o_r, o_g, o_b};
      out_last_r <= b_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_counts_clear: assert property (@(posedge clk) disable iff (!rst_n)
    advance && b_r.last |=> (cnt_r[0] == '0) && (cnt_r[1] == '0) && (cnt_r[2] == '0) &&
                            (cnt_r[3] == '0) && (cnt_r[4] == '0))
    else $error("zone counts not cleared after frame end");

  a_report_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[24] |-> out_last_r)
    else $error("action reported on a pixel that is not a frame end");

  a_zone_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r[27:25] <= bmzd_pkg::ZONE_LAST)
    else $error("action zone out of range");

endmodule
`default_nettype wire

// ===== rtl/band_motion_zone_detector.sv =====
// ----------------------------------------------------------------------------
// Band motion zone detector
// Motion detection in a sloped band of a camera stream, with zone reports.
// ----------------------------------------------------------------------------
// One pixel is taken per clock and one result leaves per clock when the
// output side keeps up; a pixel's result passes three geometry stages, the
// queue, one reference read and the output register before it is presented.
// The rate is set by the simple dual-port reference store, read once and
// written at most once per pixel. The reference needs a capture frame before
// motion frames; the user must write configuration only while no pixel is in
// flight, and the block itself does not enforce it.
`default_nettype none
module band_motion_zone_detector (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // pix_x, pix_y, in_blue, in_green, in_red
  input  wire logic        in_tuser,   // capture_frame
  input  wire logic        in_tlast,   // frame_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // out_blue, out_green, out_red, action_valid, action_zone
  output logic             out_tlast   // frame_last
);

  bmzd_pkg::cfg_t                   cfg_r;
  logic                             push_valid, q_valid, q_pop;
  bmzd_pkg::item_t                  push_item, q_item;
  logic [bmzd_pkg::QPTR_W:0]        q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_slope           <= '0;
      cfg_r.line_intercept       <= '0;
      cfg_r.x_left               <= '0;
      cfg_r.x_right              <= 10'd639;
      cfg_r.zone_width           <= '0;
      cfg_r.band_half_width      <= 8'd10;
      cfg_r.pixel_diff_threshold <= 8'd50;
      cfg_r.action_threshold     <= '0;
    end else if (cfg_we) begin
      unique case (bmzd_pkg::cfg_reg_t'(cfg_addr))
        bmzd_pkg::REG_LINE_SLOPE:     cfg_r.line_slope           <= cfg_wdata;
        bmzd_pkg::REG_LINE_INTERCEPT: cfg_r.line_intercept       <= cfg_wdata;
        bmzd_pkg::REG_X_LEFT:         cfg_r.x_left               <= cfg_wdata[9:0];
        bmzd_pkg::REG_X_RIGHT:        cfg_r.x_right              <= cfg_wdata[9:0];
        bmzd_pkg::REG_ZONE_WIDTH:     cfg_r.zone_width           <= cfg_wdata[9:0];
        bmzd_pkg::REG_BAND_HALF:      cfg_r.band_half_width      <= cfg_wdata[7:0];
        bmzd_pkg::REG_DIFF_THRESH:    cfg_r.pixel_diff_threshold <= cfg_wdata[7:0];
        bmzd_pkg::REG_ACTION_THRESH:  cfg_r.action_threshold     <= cfg_wdata[18:0];
        default: ;
      endcase
    end
  end

  bmzd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .q_count    (q_count),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  bmzd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .pop        (q_pop),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_count    (q_count)
  );

  bmzd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
